// ===== src/tbt_pkg.sv =====
// Package for the timed band thermostat: widths, scaling constants, command codes
// and the structs passed between the front, core, split and register modules.
// No dependencies.
package tbt_pkg;

   localparam int unsigned SAMPLE_BITS  = 10;    // converter resolution in use
   localparam int unsigned SAMPLE_W     = 10;    // width of the sample field on the bus
   localparam int unsigned BCD_W        = 7;
   localparam int unsigned TEMP_W       = 9;
   localparam int unsigned TIME_W       = 12;    // second of hour, duration, remain
   localparam int unsigned SET_W        = 7;
   localparam int unsigned TOL_W        = 6;
   localparam int unsigned THR_W        = 15;    // (100 +/- tol) * setpoint
   localparam int unsigned HOT_W        = TEMP_W + 7;
   localparam int unsigned MS_W         = 6;     // minutes / seconds of remaining time

   localparam int unsigned HOUR_SECONDS = 3600;
   localparam int unsigned MAX_DURATION = 3599;
   localparam int unsigned TEMP_MAX     = 511;
   localparam int unsigned PERCENT      = 100;

   // temperature = floor(sample * 1019 / 2048), the fixed-point form of sample / 2.01
   localparam int unsigned SCALE_MUL    = 1019;
   localparam int unsigned SCALE_SHIFT  = 11;

   // minutes = floor(remain * 2185 / 2^17), exact for remain below one hour
   localparam int unsigned DIV60_MUL    = 2185;
   localparam int unsigned DIV60_SHIFT  = 17;
   localparam int unsigned MINUTE       = 60;

   // register map, word index = paddr[3:2]
   localparam int unsigned CSR_ADDR_W   = 4;
   localparam logic [1:0]  REG_SETPOINT  = 2'd0;
   localparam logic [1:0]  REG_DURATION  = 2'd1;
   localparam logic [1:0]  REG_TOLERANCE = 2'd2;
   localparam logic [1:0]  REG_TIMED     = 2'd3;

   localparam logic [SET_W-1:0]  SETPOINT_RST  = 7'd45;
   localparam logic [TIME_W-1:0] DURATION_RST  = 12'd360;
   localparam logic [TOL_W-1:0]  TOLERANCE_RST = 6'd10;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_STOP   = 2'd2
   } func_type;

   // settings derived from the registers, as the core consumes them
   typedef struct packed {
      logic              timed;
      logic [TIME_W-1:0] dur_eff;
      logic [THR_W-1:0]  thr_low;
      logic [THR_W-1:0]  thr_high;
   } ctl_type;

   // decoded item held in the input register
   typedef struct packed {
      logic [1:0]        func;
      logic [TIME_W-1:0] now;
      logic [TEMP_W-1:0] temp;
   } item_type;

   // result of the control step, before the remaining time is split
   typedef struct packed {
      logic              heater_on;
      logic              fan_on;
      logic              running;
      logic              finished;
      logic [TEMP_W-1:0] temp;
      logic [TIME_W-1:0] remain;
   } rslt_type;

endpackage

// ===== src/tbt_csr.sv =====
// Configuration registers of the thermostat behind an APB-style port, plus the
// registered thresholds and clamped duration handed to the core. Uses tbt_pkg.
module tbt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tbt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output tbt_pkg::ctl_type                 ctl
);

   logic [tbt_pkg::SET_W-1:0]  setpoint_ff;
   logic [tbt_pkg::TIME_W-1:0] duration_ff;
   logic [tbt_pkg::TOL_W-1:0]  tolerance_ff;
   logic                       timed_ff;
   tbt_pkg::ctl_type           ctl_ff;
   tbt_pkg::ctl_type           ctl_in;
   logic                       wr_en;
   logic [1:0]                 reg_idx;
   logic [7:0]                 pct_low;
   logic [7:0]                 pct_high;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= tbt_pkg::SETPOINT_RST;
         duration_ff  <= tbt_pkg::DURATION_RST;
         tolerance_ff <= tbt_pkg::TOLERANCE_RST;
         timed_ff     <= 1'b1;
      end else if (wr_en) begin
         unique case (reg_idx)
            tbt_pkg::REG_SETPOINT:  setpoint_ff  <= csr_pwdata[tbt_pkg::SET_W-1:0];
            tbt_pkg::REG_DURATION:  duration_ff  <= csr_pwdata[tbt_pkg::TIME_W-1:0];
            tbt_pkg::REG_TOLERANCE: tolerance_ff <= csr_pwdata[tbt_pkg::TOL_W-1:0];
            tbt_pkg::REG_TIMED:     timed_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         tbt_pkg::REG_SETPOINT:  csr_prdata = {25'd0, setpoint_ff};
         tbt_pkg::REG_DURATION:  csr_prdata = {20'd0, duration_ff};
         tbt_pkg::REG_TOLERANCE: csr_prdata = {26'd0, tolerance_ff};
         tbt_pkg::REG_TIMED:     csr_prdata = {31'd0, timed_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // band edges in hundredths of a degree, one multiply each
   assign pct_low  = 8'(tbt_pkg::PERCENT) - {2'b00, tolerance_ff};
   assign pct_high = 8'(tbt_pkg::PERCENT) + {2'b00, tolerance_ff};

   always_comb begin
      ctl_in.timed    = timed_ff;
      ctl_in.dur_eff  = (duration_ff > 12'(tbt_pkg::MAX_DURATION))
                        ? 12'(tbt_pkg::MAX_DURATION) : duration_ff;
      ctl_in.thr_low  = 15'({7'd0, pct_low} * {8'd0, setpoint_ff});
      ctl_in.thr_high = 15'({7'd0, pct_high} * {8'd0, setpoint_ff});
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
   end

   assign ctl = ctl_ff;

endmodule

// ===== src/tbt_front.sv =====
// Input stage: decodes the BCD clock into a second of the hour, scales the
// converter sample to Celsius and holds the item in the input register. Uses tbt_pkg.
module tbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic [1:0]          req_tuser,
   input  logic                s1_ready,
   output logic                s1_valid,
   output tbt_pkg::item_type   s1_item
);

   localparam int unsigned PROD_W   = tbt_pkg::SAMPLE_BITS + 10;
   localparam int unsigned SCALED_W = PROD_W - tbt_pkg::SCALE_SHIFT;
   localparam int unsigned EXT_W    = SCALED_W + tbt_pkg::TEMP_W;

   function automatic logic [6:0] bcd_to_bin(input logic [6:0] v);
      bcd_to_bin = v - ({1'b0, v[6:4], 3'b000} - {3'b000, v[6:4], 1'b0});
   endfunction

   logic                               s1_valid_ff;
   tbt_pkg::item_type                  item_ff;
   tbt_pkg::item_type                  item_in;
   logic [6:0]                         sec_bin;
   logic [6:0]                         min_bin;
   logic [12:0]                        soh_sum;
   logic [tbt_pkg::SAMPLE_BITS-1:0]    adc;
   logic [PROD_W-1:0]                  prod;
   logic [EXT_W-1:0]                   scaled;
   logic                               take;

   assign sec_bin = bcd_to_bin(req_tdata[6:0]);
   assign min_bin = bcd_to_bin(req_tdata[13:7]);
   // seconds + 60 * minutes; at most 5185, so one conditional subtract wraps it
   assign soh_sum = {min_bin, 6'd0} - {4'd0, min_bin, 2'd0} + {6'd0, sec_bin};

   assign adc    = req_tdata[14 +: tbt_pkg::SAMPLE_BITS];
   assign prod   = PROD_W'(adc) * PROD_W'(tbt_pkg::SCALE_MUL);
   assign scaled = EXT_W'(prod[PROD_W-1:tbt_pkg::SCALE_SHIFT]);

   always_comb begin
      item_in.func = req_tuser;
      item_in.now  = (soh_sum >= 13'(tbt_pkg::HOUR_SECONDS))
                     ? 12'(soh_sum - 13'(tbt_pkg::HOUR_SECONDS)) : soh_sum[11:0];
      item_in.temp = (scaled > EXT_W'(tbt_pkg::TEMP_MAX))
                     ? tbt_pkg::TEMP_W'(tbt_pkg::TEMP_MAX) : scaled[tbt_pkg::TEMP_W-1:0];
   end

   assign req_tready = !s1_valid_ff || s1_ready;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = item_ff;

endmodule

// ===== src/tbt_core.sv =====
// Control step: run flag, start time, heater and fan state, countdown and band
// rule, applied once per item as it leaves the input register. Uses tbt_pkg.
module tbt_core (
   input  logic                clock,
   input  logic                reset,
   input  tbt_pkg::ctl_type    ctl,
   input  logic                s1_valid,
   output logic                s1_ready,
   input  tbt_pkg::item_type   s1_item,
   output logic                s2_valid,
   input  logic                s2_ready,
   output tbt_pkg::rslt_type   s2_rslt
);

   logic                         s2_valid_ff;
   tbt_pkg::rslt_type            rslt_ff;
   tbt_pkg::rslt_type            rslt_in;
   logic                         run_ff, run_in;
   logic [tbt_pkg::TIME_W-1:0]   start_ff, start_in;
   logic                         heat_ff, heat_in;
   logic                         fan_ff, fan_in;
   logic                         fin;
   logic [tbt_pkg::TIME_W:0]     diff;
   logic [tbt_pkg::TIME_W-1:0]   elapsed;
   logic [tbt_pkg::TIME_W-1:0]   remain;
   logic [tbt_pkg::TEMP_W-1:0]   temp_out;
   logic [tbt_pkg::HOT_W-1:0]    hot;
   logic                         fire;

   // elapsed = (now - start) mod 3600, both below 3600
   assign diff    = {1'b0, s1_item.now} - {1'b0, start_ff};
   assign elapsed = diff[tbt_pkg::TIME_W]
                    ? diff[tbt_pkg::TIME_W-1:0] + 12'(tbt_pkg::HOUR_SECONDS)
                    : diff[tbt_pkg::TIME_W-1:0];

   // 100 * temperature
   assign hot = {1'b0, s1_item.temp, 6'd0} + {2'd0, s1_item.temp, 5'd0}
              + {5'd0, s1_item.temp, 2'd0};

   always_comb begin
      run_in   = run_ff;
      start_in = start_ff;
      heat_in  = heat_ff;
      fan_in   = fan_ff;
      fin      = 1'b0;
      temp_out = '0;
      remain   = '0;
      unique case (tbt_pkg::func_type'(s1_item.func))
         tbt_pkg::FUNC_START: begin
            run_in   = 1'b1;
            start_in = s1_item.now;
            if (ctl.timed) begin
               remain = ctl.dur_eff;
            end
         end
         tbt_pkg::FUNC_SAMPLE: begin
            temp_out = s1_item.temp;
            if (run_ff) begin
               if (ctl.timed) begin
                  // overrun and exact expiry both end the run
                  if (elapsed >= ctl.dur_eff) begin
                     fin = 1'b1;
                  end else begin
                     remain = ctl.dur_eff - elapsed;
                  end
               end
               priority if (hot < {1'b0, ctl.thr_low}) begin
                  heat_in = 1'b1;
                  fan_in  = 1'b1;
               end else if (hot <= {1'b0, ctl.thr_high}) begin
                  heat_in = 1'b0;
                  fan_in  = 1'b1;
               end
            end
         end
         tbt_pkg::FUNC_STOP: begin
            fin = run_ff;
         end
         default: ;
      endcase
      if (fin) begin
         run_in  = 1'b0;
         heat_in = 1'b0;
         fan_in  = 1'b0;
      end
      rslt_in.heater_on = heat_in;
      rslt_in.fan_on    = fan_in;
      rslt_in.running   = run_in;
      rslt_in.finished  = fin;
      rslt_in.temp      = temp_out;
      rslt_in.remain    = remain;
   end

   assign s1_ready = !s2_valid_ff || s2_ready;
   assign fire     = s1_valid && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         run_ff      <= 1'b0;
         start_ff    <= '0;
         heat_ff     <= 1'b0;
         fan_ff      <= 1'b0;
      end else begin
         if (s1_ready) begin
            s2_valid_ff <= s1_valid;
         end
         if (fire) begin
            run_ff   <= run_in;
            start_ff <= start_in;
            heat_ff  <= heat_in;
            fan_ff   <= fan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rslt_ff <= rslt_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_rslt  = rslt_ff;

   a_fin_drops_all: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && rslt_ff.finished |-> !rslt_ff.running && !rslt_ff.heater_on
                                          && !rslt_ff.fan_on)
      else $error("finished result still shows a live run or drive");

   a_heat_needs_fan: assert property (@(posedge clock) disable iff (reset)
      heat_ff |-> fan_ff)
      else $error("heater on with fan off");

   a_idle_drives_off: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> !heat_ff && !fan_ff)
      else $error("drive on while no run is in progress");

endmodule

// ===== src/tbt_split.sv =====
// Output stage: splits the remaining time into minutes and seconds and holds the
// packed result item until the consumer takes it. Uses tbt_pkg.
module tbt_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                s2_valid,
   output logic                s2_ready,
   input  tbt_pkg::rslt_type   s2_rslt,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata
);

   localparam int unsigned PROD_W = 2 * tbt_pkg::TIME_W;

   logic                         rsp_valid_ff;
   logic [31:0]                  data_ff;
   logic [31:0]                  data_in;
   logic [PROD_W-1:0]            prod;
   logic [6:0]                   quot;
   logic [tbt_pkg::TIME_W:0]     rem;
   logic [tbt_pkg::MS_W-1:0]     minutes;
   logic [tbt_pkg::MS_W-1:0]     seconds;
   logic                         load;

   assign prod = PROD_W'(s2_rslt.remain) * PROD_W'(tbt_pkg::DIV60_MUL);
   assign quot = prod[tbt_pkg::DIV60_SHIFT +: 7];
   // remain - 60 * quot
   assign rem  = {1'b0, s2_rslt.remain} - ({quot, 6'd0} - {4'd0, quot, 2'd0});

   always_comb begin
      if (rem >= 13'(tbt_pkg::MINUTE)) begin
         minutes = 6'(quot + 7'd1);
         seconds = 6'(rem - 13'(tbt_pkg::MINUTE));
      end else begin
         minutes = quot[tbt_pkg::MS_W-1:0];
         seconds = rem[tbt_pkg::MS_W-1:0];
      end
      data_in = {7'd0, seconds, minutes, s2_rslt.temp, s2_rslt.finished,
                 s2_rslt.running, s2_rslt.fan_on, s2_rslt.heater_on};
   end

   assign s2_ready = !rsp_valid_ff || rsp_tready;
   assign load     = s2_valid && s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> data_ff[24:19] < 6'(tbt_pkg::MINUTE)
                       && data_ff[18:13] < 6'(tbt_pkg::MINUTE))
      else $error("remaining minutes or seconds out of range");

endmodule

// ===== src/timed_band_thermostat.sv =====
// Top level of the timed band thermostat: register port, input stage, control
// core and output stage. Depends on tbt_pkg, tbt_csr, tbt_front, tbt_core, tbt_split.
//
//   port group | direction | carries
//   -----------+-----------+---------------------------------------------------
//   req_*      | in        | item: start / sample / stop with clock and reading
//   rsp_*      | out       | item: drives, run status, temperature, time left
//   csr_*      | in/out    | setpoint, duration, tolerance, timed mode
//
// Throughput: one item per cycle while rsp_tready is held high; an item passes the
// input register, then the control register, then the output register before its
// result can be taken.
// The only loop is the run, start time, heater and fan state, updated once per item.
// Reset: synchronous, clears valid bits, run state, drives and the registers to
// their defaults; no clearing pass, items are taken the first cycle after reset.
// Stalls: each stage refills as soon as its contents move on, so a held result
// does not block the two stages behind it until they too are full.
module timed_band_thermostat (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: clock_seconds_bcd [6:0], clock_minutes_bcd [13:7], sensor_sample [23:14]
   input  logic [23:0]                      req_tdata,
   // tuser: func [1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: heater_on [0], fan_on [1], running [2], finished [3], temperature_c [12:4],
   //        remain_minutes [18:13], remain_seconds [24:19], zero [31:25]
   output logic [31:0]                      rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tbt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   tbt_pkg::ctl_type    ctl;
   tbt_pkg::item_type   s1_item;
   tbt_pkg::rslt_type   s2_rslt;
   logic                s1_valid;
   logic                s1_ready;
   logic                s2_valid;
   logic                s2_ready;

   // registers; the thresholds are registered from them and follow a write in the next cycle
   tbt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctl         (ctl)
   );

   // decode the clock, scale the reading, hold the item
   tbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .s1_ready   (s1_ready),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item)
   );

   // advance the run state and apply the band rule
   tbt_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_item  (s1_item),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .s2_rslt  (s2_rslt)
   );

   // split remaining time, pack and hold the result item
   tbt_split u_split (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2_ready   (s2_ready),
      .s2_rslt    (s2_rslt),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
